>>> rtl/core/drfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drfl_pkg
// shared types and constants of the descriptor range free list
// ----------------------------------------------------------------------------
package drfl_pkg;

    localparam int SLOT_W         = 10;
    localparam int CFG_W          = 11;
    localparam int DEF_SLOT_COUNT = 1024;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_SHIFT_DN,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_INSERT
    } drfl_state_t;

endpackage
`default_nettype wire

>>> rtl/core/drfl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drfl_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module drfl_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> rtl/core/descriptor_range_free_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// descriptor_range_free_list
// slot allocator over an ordered list of free ranges kept in one ram
// ----------------------------------------------------------------------------
// usage:
//   a command is taken when start is high and busy is low. kind selects
//   allocate or free of slot_index. each command gives one result word on
//   granted_index / no_free_slot, marked by a one-cycle done strobe that the
//   receiver must take; there is no backpressure on the result side.
//   slot_count is written through cfg_valid / cfg_ready / cfg_data while the
//   block is idle and no command is offered; it rebuilds the list as one
//   range [0, slot_count).
// sequence of work (T = number of ranges):
//   allocate: reads and trims the first range, answers an empty list from
//   idle, or moves the list down one entry per cycle when the first range runs empty.
//   free: answers an empty list from idle, else scans from entry 0 up to the
//   entry i that merges or lies above the slot; an insert then shifts the T - i
//   tail entries up. the single ram port pair sets the pace: one entry read and
//   one written per cycle. worst case is an insert with MAX_RANGES - 1 ranges.
// reset: list holds [0, min(1024, MAX_SLOTS)); no clearing pass is needed,
//   entry 0 is served from registers until first written.
// ----------------------------------------------------------------------------
module descriptor_range_free_list #(
    parameter int MAX_SLOTS  = 1024,
    parameter int MAX_RANGES = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        kind,
    input  wire logic [drfl_pkg::SLOT_W-1:0] slot_index,
    output logic                             done,
    output logic      [drfl_pkg::SLOT_W-1:0] granted_index,
    output logic                             no_free_slot,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [drfl_pkg::CFG_W-1:0]  cfg_data
);

    import drfl_pkg::*;

    localparam int SW = ($clog2(MAX_SLOTS + 1) > CFG_W) ? $clog2(MAX_SLOTS + 1) : CFG_W;
    localparam int AW = $clog2(MAX_RANGES);
    localparam int TW = $clog2(MAX_RANGES + 1);
    localparam int CW = TW + 1;
    localparam int EW = 2 * SW;
    localparam int RESET_COUNT = (MAX_SLOTS < DEF_SLOT_COUNT) ? MAX_SLOTS : DEF_SLOT_COUNT;

    drfl_state_t   state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [TW-1:0] total_reg, total_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [SW-1:0] slot_count_reg;
    logic          fresh_reg, fresh_next;
    logic          rd_fresh_reg;
    logic          done_reg, done_next;
    logic          fail_reg, fail_next;
    logic [SLOT_W-1:0] granted_reg, granted_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] wr_data, ram_q, ent;
    logic [SW-1:0] ent_start, ent_end, new_start, slot_in, slot1;
    logic [SW-1:0] cfg_ext, cfg_count;
    logic [CW-1:0] idx_w, total_w;
    logic          cfg_wr;

    drfl_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_RANGES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // entry 0 is virtual until first written after reset or reconfiguration
    assign ent       = rd_fresh_reg ? {SW'(0), slot_count_reg} : ram_q;
    assign ent_start = ent[EW-1:SW];
    assign ent_end   = ent[SW-1:0];
    assign new_start = ent_start + SW'(1);
    assign slot_in   = SW'(slot_index);
    assign slot1     = slot_reg + SW'(1);
    assign idx_w     = CW'(idx_reg);
    assign total_w   = CW'(total_reg);

    // a command offered in the same cycle goes first
    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_ext   = SW'(cfg_data);

    always_comb
    begin
        if (cfg_ext == '0)
            cfg_count = SW'(1);
        else if (cfg_ext > SW'(MAX_SLOTS))
            cfg_count = SW'(MAX_SLOTS);
        else
            cfg_count = cfg_ext;
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        slot_next    = slot_reg;
        done_next    = 1'b0;
        fail_next    = fail_reg;
        granted_next = granted_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    slot_next    = slot_in;
                    granted_next = '0;
                    fail_next    = 1'b0;
                    if (kind == KIND_ALLOC)
                    begin
                        if (total_reg == '0)
                        begin
                            fail_next = 1'b1;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_ALLOC;
                        end
                    end
                    else if (total_reg == '0)
                    begin
                        // empty list: the new range goes straight to entry 0
                        wr_en      = 1'b1;
                        wr_data    = {slot_in, slot_in + SW'(1)};
                        total_next = TW'(1);
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_ALLOC:
            begin
                granted_next = ent_start[SLOT_W-1:0];
                if (new_start >= ent_end)
                begin
                    total_next = total_reg - TW'(1);
                    if (total_reg > TW'(1))
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(1);
                        idx_next   = '0;
                        state_next = ST_SHIFT_DN;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = {new_start, ent_end};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SHIFT_DN:
            begin
                // total_reg already holds the shortened count
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = ent;
                if ((idx_w + CW'(2)) <= total_w)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(idx_w + CW'(2));
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                priority if (ent_start == slot1)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg;
                    wr_data    = {slot_reg, ent_end};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (ent_end == slot_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg;
                    wr_data    = {ent_start, slot1};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (ent_start > slot_reg)
                begin
                    if (total_reg == TW'(MAX_RANGES))
                    begin
                        fail_next  = 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // move the tail up from the last entry down to idx
                        pos_next   = idx_reg;
                        rd_en      = 1'b1;
                        rd_addr    = AW'(total_reg - TW'(1));
                        idx_next   = AW'(total_reg - TW'(1));
                        state_next = ST_SHIFT_UP;
                    end
                end
                else if ((idx_w + CW'(1)) < total_w)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
                else if (total_reg == TW'(MAX_RANGES))
                begin
                    fail_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // append at the tail
                    wr_en      = 1'b1;
                    wr_addr    = AW'(total_reg);
                    wr_data    = {slot_reg, slot1};
                    total_next = total_reg + TW'(1);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SHIFT_UP:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg + AW'(1);
                wr_data = ent;
                if (idx_reg > pos_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg - AW'(1);
                    idx_next = idx_reg - AW'(1);
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end

            ST_INSERT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = {slot_reg, slot1};
                total_next = total_reg + TW'(1);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        fresh_next = fresh_reg && !(wr_en && (wr_addr == '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            total_reg      <= TW'(1);
            slot_count_reg <= SW'(RESET_COUNT);
            fresh_reg      <= 1'b1;
            rd_fresh_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            rd_fresh_reg <= rd_en && (rd_addr == '0) && fresh_reg;
            if (cfg_wr)
            begin
                slot_count_reg <= cfg_count;
                total_reg      <= TW'(1);
                fresh_reg      <= 1'b1;
            end
            else
            begin
                total_reg <= total_next;
                fresh_reg <= fresh_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        slot_reg    <= slot_next;
        fail_reg    <= fail_next;
        granted_reg <= granted_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign granted_index = granted_reg;
    assign no_free_slot  = fail_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TW'(MAX_RANGES))
        else $error("range count above table depth");

    a_done_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("command finished without a result word");

    a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("ram read and write hit the same entry");

    a_fail_zero_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_free_slot) |-> (granted_index == '0))
        else $error("failed command carries a granted index");

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for descriptor_range_free_list: a clocked driver feeds
// allocate / free commands and slot_count writes from a queue, a predictor of
// the free range list computes each result word, and a clocked monitor
// compares every done word against the oldest prediction
// ----------------------------------------------------------------------------
module tb;

    import drfl_pkg::*;

    localparam int MAX_SLOTS  = 1024;
    localparam int MAX_RANGES = 1024;
    localparam int SETTLE     = 2100;

    typedef enum logic [1:0] {
        STEP_CMD,
        STEP_CFG,
        STEP_DRAIN
    } step_t;

    typedef struct {
        step_t             op;
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [CFG_W-1:0]  count;
    } step_item_t;

    typedef struct {
        logic              kind;
        logic [SLOT_W-1:0] granted_index;
        logic              no_free_slot;
    } grant_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic              kind       = KIND_ALLOC;
    logic [SLOT_W-1:0] slot_index = '0;
    logic              cfg_valid  = 1'b0;
    logic [CFG_W-1:0]  cfg_data   = '0;
    logic              busy;
    logic              done;
    logic [SLOT_W-1:0] granted_index;
    logic              no_free_slot;
    logic              cfg_ready;

    // predicted free list
    logic [CFG_W-1:0] free_lo [MAX_RANGES];
    logic [CFG_W-1:0] free_hi [MAX_RANGES];
    int unsigned      range_cnt;
    logic [CFG_W-1:0] slots_in_use;

    step_item_t        steps_q [$];
    grant_t            grants_due [$];
    logic [SLOT_W-1:0] held_slots [$];

    int  gap_left   = 0;
    bit  burst_on   = 1'b1;
    bit  quiet_tail = 1'b0;
    bit  start_n;
    bit  cfg_valid_n;
    int  n_alloc    = 0;
    int  n_free     = 0;
    int  n_flag     = 0;
    int  n_cfg      = 0;
    int  n_err      = 0;

    descriptor_range_free_list #(
        .MAX_SLOTS  (MAX_SLOTS),
        .MAX_RANGES (MAX_RANGES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .slot_index    (slot_index),
        .done          (done),
        .granted_index (granted_index),
        .no_free_slot  (no_free_slot),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CFG_W-1:0] clamp_slot_count(logic [CFG_W-1:0] v);
        if (v == '0)
            return CFG_W'(1);
        if (v > MAX_SLOTS)
            return CFG_W'(MAX_SLOTS);
        return v;
    endfunction

    function automatic void rebuild_free_list();
        free_lo[0] = '0;
        free_hi[0] = slots_in_use;
        range_cnt  = 1;
    endfunction

    function automatic void drop_range(int unsigned pos);
        for (int unsigned i = pos; i + 1 < range_cnt; i++)
        begin
            free_lo[i] = free_lo[i + 1];
            free_hi[i] = free_hi[i + 1];
        end
        range_cnt--;
    endfunction

    function automatic void add_range(int unsigned pos, logic [CFG_W-1:0] s);
        for (int unsigned i = range_cnt; i > pos; i--)
        begin
            free_lo[i] = free_lo[i - 1];
            free_hi[i] = free_hi[i - 1];
        end
        free_lo[pos] = s;
        free_hi[pos] = s + 11'd1;
        range_cnt++;
    endfunction

    // applies one command to the predicted list and returns its result word
    function automatic grant_t next_grant(logic k, logic [SLOT_W-1:0] s);
        grant_t           r;
        logic [CFG_W-1:0] s_ext;
        int unsigned      ins_at;
        bit               touched;
        r.kind          = k;
        r.granted_index = '0;
        r.no_free_slot  = 1'b0;
        s_ext           = {1'b0, s};
        ins_at          = range_cnt;
        touched         = 1'b0;
        if (k == KIND_ALLOC)
        begin
            if (range_cnt == 0)
                r.no_free_slot = 1'b1;
            else
            begin
                r.granted_index = free_lo[0][SLOT_W-1:0];
                free_lo[0]      = free_lo[0] + 11'd1;
                if (free_lo[0] >= free_hi[0])
                    drop_range(0);
            end
        end
        else
        begin
            for (int unsigned i = 0; i < range_cnt; i++)
            begin
                if (free_lo[i] == s_ext + 11'd1)
                begin
                    free_lo[i] = s_ext;
                    touched    = 1'b1;
                    break;
                end
                else if (free_hi[i] == s_ext)
                begin
                    free_hi[i] = s_ext + 11'd1;
                    touched    = 1'b1;
                    break;
                end
                else if (free_lo[i] > s_ext)
                begin
                    ins_at = i;
                    break;
                end
            end
            if (!touched)
            begin
                if (range_cnt >= MAX_RANGES)
                    r.no_free_slot = 1'b1;
                else
                    add_range(ins_at, s_ext);
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            kind         <= KIND_ALLOC;
            slot_index   <= '0;
            cfg_valid    <= 1'b0;
            cfg_data     <= '0;
            gap_left     = 0;
            slots_in_use = clamp_slot_count(11'(DEF_SLOT_COUNT));
            rebuild_free_list();
        end
        else
        begin
            start_n     = start;
            cfg_valid_n = cfg_valid;
            if (start && !busy)
            begin
                grants_due.insert(grants_due.size(), next_grant(kind, slot_index));
                if (kind == KIND_ALLOC)
                    n_alloc++;
                else
                    n_free++;
                start_n = 1'b0;
                if (!quiet_tail && burst_on && $urandom_range(0, 2) == 0)
                    gap_left = $urandom_range(1, 13);
                if ($urandom_range(0, 39) == 0)
                    burst_on = !burst_on;
            end
            if (cfg_valid && cfg_ready)
            begin
                slots_in_use = clamp_slot_count(cfg_data);
                rebuild_free_list();
                n_cfg++;
                cfg_valid_n = 1'b0;
            end
            if (!start_n && !cfg_valid_n)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (steps_q.size() > 0)
                begin
                    case (steps_q[0].op)
                        STEP_CMD:
                        begin
                            start_n    = 1'b1;
                            kind       <= steps_q[0].kind;
                            slot_index <= steps_q[0].slot;
                            steps_q.delete(0);
                        end
                        STEP_CFG:
                        begin
                            if (grants_due.size() == 0 && !busy)
                            begin
                                cfg_valid_n = 1'b1;
                                cfg_data    <= steps_q[0].count;
                                steps_q.delete(0);
                            end
                        end
                        default:
                        begin
                            if (grants_due.size() == 0)
                                steps_q.delete(0);
                        end
                    endcase
                end
            end
            start     <= start_n;
            cfg_valid <= cfg_valid_n;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (grants_due.size() == 0)
            begin
                $error("unexpected result word: granted_index %0d no_free_slot %0d",
                       granted_index, no_free_slot);
                n_err++;
            end
            else
            begin
                if (granted_index !== grants_due[0].granted_index)
                begin
                    $error("granted_index: expected %0d, got %0d",
                           grants_due[0].granted_index, granted_index);
                    n_err++;
                end
                if (no_free_slot !== grants_due[0].no_free_slot)
                begin
                    $error("no_free_slot: expected %0d, got %0d",
                           grants_due[0].no_free_slot, no_free_slot);
                    n_err++;
                end
                if (grants_due[0].no_free_slot)
                    n_flag++;
                else if (grants_due[0].kind == KIND_ALLOC)
                    held_slots.insert(held_slots.size(), grants_due[0].granted_index);
                grants_due.delete(0);
            end
        end
    end

    task automatic push_cmd(logic k, logic [SLOT_W-1:0] s);
        step_item_t it;
        it.op    = STEP_CMD;
        it.kind  = k;
        it.slot  = s;
        it.count = '0;
        steps_q.insert(steps_q.size(), it);
    endtask

    task automatic push_cfg(logic [CFG_W-1:0] v);
        step_item_t it;
        it.op    = STEP_CFG;
        it.kind  = KIND_ALLOC;
        it.slot  = '0;
        it.count = v;
        steps_q.insert(steps_q.size(), it);
        held_slots.delete();
    endtask

    task automatic push_drain();
        step_item_t it;
        it.op    = STEP_DRAIN;
        it.kind  = KIND_ALLOC;
        it.slot  = '0;
        it.count = '0;
        steps_q.insert(steps_q.size(), it);
    endtask

    task automatic wait_idle();
        while (steps_q.size() > 0 || grants_due.size() > 0)
            @(posedge clk);
    endtask

    // random batch: allocates and frees, most frees of slots handed out earlier, some noise frees
    task automatic queue_phase(int n);
        int pick;
        int sel;
        sel = $urandom_range(0, 4);
        case (sel)
            0: push_cfg(11'($urandom_range(1, 16)));
            1: push_cfg(11'($urandom_range(17, 200)));
            2: push_cfg(11'($urandom_range(0, 2047)));
            3: push_cfg(11'(MAX_SLOTS));
            default: ;
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2 && $urandom_range(0, 1) == 0)
                push_drain();
            if ($urandom_range(0, 99) < 45)
                push_cmd(KIND_ALLOC, 10'($urandom_range(0, 1023)));
            else if (held_slots.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, held_slots.size() - 1);
                push_cmd(KIND_FREE, held_slots[pick]);
                held_slots.delete(pick);
            end
            else
                push_cmd(KIND_FREE, 10'($urandom_range(0, 1023)));
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: overlaps, end growth, empty list, count clamping
        push_cmd(KIND_ALLOC, 10'h3FF);
        push_cmd(KIND_ALLOC, 10'h000);
        push_cmd(KIND_FREE, 10'd0);
        push_cmd(KIND_FREE, 10'd1);
        push_cmd(KIND_FREE, 10'h3FF);
        push_cmd(KIND_FREE, 10'd3);
        push_cmd(KIND_FREE, 10'h155);
        push_cmd(KIND_FREE, 10'h2AA);
        push_cmd(KIND_ALLOC, 10'd0);
        push_cmd(KIND_ALLOC, 10'd0);
        push_cfg(11'd1);
        push_cmd(KIND_ALLOC, 10'd0);
        push_cmd(KIND_ALLOC, 10'd0);
        push_cmd(KIND_FREE, 10'd0);
        push_cmd(KIND_FREE, 10'd1);
        push_cmd(KIND_ALLOC, 10'd0);
        push_cmd(KIND_ALLOC, 10'd0);
        push_cmd(KIND_ALLOC, 10'd0);
        push_cfg(11'd0);
        push_cmd(KIND_ALLOC, 10'd0);
        push_cmd(KIND_ALLOC, 10'd0);
        push_cfg(11'h7FF);
        push_cmd(KIND_ALLOC, 10'd0);
        push_cmd(KIND_FREE, 10'd0);
        wait_idle();

        for (int p = 0; p < 9; p++)
            queue_phase(60);

        // last stretch with no random gaps between commands
        quiet_tail = 1'b1;
        queue_phase(20);

        repeat (SETTLE) @(posedge clk);
        $display("tb: %0d allocate and %0d free commands checked, %0d no_free_slot flags",
                 n_alloc, n_free, n_flag);
        $display("tb: %0d slot_count writes, with overlapping and duplicate frees mixed in",
                 n_cfg);
        if (n_err == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/drfl_pkg.sv
rtl/core/drfl_ram.sv
rtl/core/descriptor_range_free_list.sv
dv/tb.sv
